@@ rtl/ngpd_pkg.sv @@
package ngpd_pkg;

    // defaults for the top-level parameters
    localparam int SIDE_MAX_DEF        = 32;
    localparam int COORD_FRAC_BITS_DEF = 24;
    localparam int MASS_BITS_DEF       = 32;
    localparam int ACC_BITS_DEF        = 40;

    // fixed port widths
    localparam int POS_W     = 24;
    localparam int MASS_W    = 32;
    localparam int IDX_W     = 5;
    localparam int TOTAL_W   = 40;
    localparam int SIZE_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        OP_DEPOSIT = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

@@ rtl/ngp_mass_deposit_3d.sv @@
// Nearest-grid-point mass deposit onto a periodic 3D grid.
// Command channel: drive start with the operation and its fields; the
// transaction is taken at the clock edge where start is high and busy low.
// A deposit scales each coordinate by its axis size, rounds half-up, wraps
// and adds mass to that cell (saturating); a read returns a cell total.
// Result channel: every transaction yields one result, shown for exactly one
// cycle with o_strobe high. The receiver cannot hold results off and none
// is needed: the back end returns to idle between any two results. With an
// empty queue and an idle back end, a transaction goes from the accepting
// edge through the stage 1 register, a queue write, the RAM read and the
// update into the output register, which raises o_strobe. The back end
// ends the read-then-write of one entry in the single-port-per-direction
// grid RAM before it pops the next. Sizes are written on the cfg port
// (index 0..2 = x, y, z); the user must write them only while idle; the
// block does not enforce it. Reset: sizes return to 32 and the grid RAM
// is cleared over all SIDE_MAX^3 cells (32768 by default) with busy high.
module ngp_mass_deposit_3d #(
    parameter int SIDE_MAX        = ngpd_pkg::SIDE_MAX_DEF,
    parameter int COORD_FRAC_BITS = ngpd_pkg::COORD_FRAC_BITS_DEF,
    parameter int MASS_BITS       = ngpd_pkg::MASS_BITS_DEF,
    parameter int ACC_BITS        = ngpd_pkg::ACC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ngpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ngpd_pkg::SIZE_W-1:0]     i_cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [ngpd_pkg::POS_W-1:0]      i_pos_x,
    input  logic [ngpd_pkg::POS_W-1:0]      i_pos_y,
    input  logic [ngpd_pkg::POS_W-1:0]      i_pos_z,
    input  logic [ngpd_pkg::MASS_W-1:0]     i_mass,
    input  logic [ngpd_pkg::IDX_W-1:0]      i_read_x,
    input  logic [ngpd_pkg::IDX_W-1:0]      i_read_y,
    input  logic [ngpd_pkg::IDX_W-1:0]      i_read_z,
    output logic                            o_strobe,
    output logic [ngpd_pkg::IDX_W-1:0]      o_out_cell_x,
    output logic [ngpd_pkg::IDX_W-1:0]      o_out_cell_y,
    output logic [ngpd_pkg::IDX_W-1:0]      o_out_cell_z,
    output logic [ngpd_pkg::TOTAL_W-1:0]    o_cell_total,
    output logic                            o_saturated
);
    import ngpd_pkg::*;

    localparam int CELL_W  = $clog2(SIDE_MAX);
    localparam int ADDR_W  = $clog2(SIDE_MAX * SIDE_MAX * SIDE_MAX);
    // queue entry: op, address, x, y, z, mass
    localparam int ENTRY_W = 1 + ADDR_W + 3 * CELL_W + MASS_BITS;

    t_q_status          w_q_status;
    t_back_status       w_back_status;
    logic               w_push, w_pop;
    logic [ENTRY_W-1:0] w_push_data, w_pop_data;

    // front: config registers, scaling, rounding, addressing
    ngpd_front #(
        .SIDE_MAX        (SIDE_MAX),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .MASS_BITS       (MASS_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .i_operation (i_operation),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_mass      (i_mass),
        .i_read_x    (i_read_x),
        .i_read_y    (i_read_y),
        .i_read_z    (i_read_z),
        .i_back      (w_back_status),
        .i_q         (w_q_status),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // two-entry queue decouples front from the RAM sequencer
    ngpd_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    // back: clearing pass, read-modify-write of the grid, results
    ngpd_back #(
        .SIDE_MAX  (SIDE_MAX),
        .MASS_BITS (MASS_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (w_q_status),
        .i_entry      (w_pop_data),
        .o_pop        (w_pop),
        .o_status     (w_back_status),
        .o_strobe     (o_strobe),
        .o_out_cell_x (o_out_cell_x),
        .o_out_cell_y (o_out_cell_y),
        .o_out_cell_z (o_out_cell_z),
        .o_cell_total (o_cell_total),
        .o_saturated  (o_saturated)
    );

    // nothing may be taken while the grid is being cleared
    a_busy_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_status.clearing |-> busy)
        else $error("transaction possible during clearing pass");

endmodule

@@ rtl/ngpd_ram.sv @@
module ngpd_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32768,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ngpd_front.sv @@
module ngpd_front #(
    parameter int SIDE_MAX        = ngpd_pkg::SIDE_MAX_DEF,
    parameter int COORD_FRAC_BITS = ngpd_pkg::COORD_FRAC_BITS_DEF,
    parameter int MASS_BITS       = ngpd_pkg::MASS_BITS_DEF,
    localparam int CELL_W  = $clog2(SIDE_MAX),
    localparam int ADDR_W  = $clog2(SIDE_MAX * SIDE_MAX * SIDE_MAX),
    localparam int ENTRY_W = 1 + ADDR_W + 3 * CELL_W + MASS_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ngpd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ngpd_pkg::SIZE_W-1:0]         i_cfg_wdata,
    input  logic                                start,
    input  logic                                i_operation,
    input  logic [ngpd_pkg::POS_W-1:0]          i_pos_x,
    input  logic [ngpd_pkg::POS_W-1:0]          i_pos_y,
    input  logic [ngpd_pkg::POS_W-1:0]          i_pos_z,
    input  logic [ngpd_pkg::MASS_W-1:0]         i_mass,
    input  logic [ngpd_pkg::IDX_W-1:0]          i_read_x,
    input  logic [ngpd_pkg::IDX_W-1:0]          i_read_y,
    input  logic [ngpd_pkg::IDX_W-1:0]          i_read_z,
    input  ngpd_pkg::t_back_status              i_back,
    input  ngpd_pkg::t_q_status                 i_q,
    output logic                                o_busy,
    output logic                                o_push,
    output logic [ENTRY_W-1:0]                  o_push_data
);
    import ngpd_pkg::*;

    localparam int N_W    = $clog2(SIDE_MAX + 1);
    localparam int PROD_W = N_W + COORD_FRAC_BITS;

    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;

    logic              r_s1_valid, n_s1_valid;
    logic              r_op;
    logic [PROD_W-1:0] r_prod_x, r_prod_y, r_prod_z;
    logic [MASS_BITS-1:0] r_mass;
    logic [IDX_W-1:0]  r_rd_x, r_rd_y, r_rd_z;

    logic [N_W-1:0]    w_n_x, w_n_y, w_n_z;
    logic              w_accept;
    logic [CELL_W-1:0] w_ix, w_iy, w_iz;
    logic [ADDR_W-1:0] w_addr;
    logic [CELL_W-1:0] w_mod_tab [2**IDX_W];

    function automatic logic [N_W-1:0] f_in_use(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return N_W'(1);
        end else if (32'(s) > 32'(SIDE_MAX)) begin
            return N_W'(SIDE_MAX);
        end else begin
            return N_W'(s);
        end
    endfunction

    // round half-up, then wrap an index equal to the size
    function automatic logic [CELL_W-1:0] f_ngp(input logic [PROD_W-1:0] prod,
                                                input logic [N_W-1:0]    n);
        logic [PROD_W:0] sum;
        logic [N_W-1:0]  idx;
        sum = {1'b0, prod} + ((PROD_W + 1)'(1) << (COORD_FRAC_BITS - 1));
        idx = sum[COORD_FRAC_BITS +: N_W];
        if (idx >= n) begin
            idx = idx - n;
        end
        return CELL_W'(idx);
    endfunction

    // read index modulo SIDE_MAX
    for (genvar g = 0; g < 2**IDX_W; g++) begin : g_mod
        assign w_mod_tab[g] = CELL_W'(g % SIDE_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIZE_X: r_size_x <= i_cfg_wdata;
                REG_SIZE_Y: r_size_y <= i_cfg_wdata;
                REG_SIZE_Z: r_size_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_n_x = f_in_use(r_size_x);
    assign w_n_y = f_in_use(r_size_y);
    assign w_n_z = f_in_use(r_size_z);

    assign o_busy   = i_back.clearing || (r_s1_valid && i_q.full);
    assign w_accept = start && !o_busy;
    assign o_push   = r_s1_valid && !i_q.full;

    assign n_s1_valid = w_accept || (r_s1_valid && !o_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // stage 1: scale by the size in use
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_operation;
            r_prod_x <= PROD_W'(w_n_x) * PROD_W'(COORD_FRAC_BITS'(i_pos_x));
            r_prod_y <= PROD_W'(w_n_y) * PROD_W'(COORD_FRAC_BITS'(i_pos_y));
            r_prod_z <= PROD_W'(w_n_z) * PROD_W'(COORD_FRAC_BITS'(i_pos_z));
            r_mass   <= MASS_BITS'(i_mass);
            r_rd_x   <= i_read_x;
            r_rd_y   <= i_read_y;
            r_rd_z   <= i_read_z;
        end
    end

    // stage 2: cell index and address, into the queue
    always_comb begin
        if (r_op == OP_READ) begin
            w_ix = w_mod_tab[r_rd_x];
            w_iy = w_mod_tab[r_rd_y];
            w_iz = w_mod_tab[r_rd_z];
        end else begin
            w_ix = f_ngp(r_prod_x, w_n_x);
            w_iy = f_ngp(r_prod_y, w_n_y);
            w_iz = f_ngp(r_prod_z, w_n_z);
        end
        w_addr = (ADDR_W'(w_ix) * ADDR_W'(SIDE_MAX) + ADDR_W'(w_iy)) * ADDR_W'(SIDE_MAX)
               + ADDR_W'(w_iz);
    end

    assign o_push_data = {r_op, w_addr, w_ix, w_iy, w_iz, r_mass};

endmodule

@@ rtl/ngpd_queue.sv @@
module ngpd_queue #(
    parameter int WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_push_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_pop_data,
    output ngpd_pkg::t_q_status   o_status
);
    import ngpd_pkg::*;

    logic [WIDTH-1:0] r_data [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_data[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue popped while empty");

    a_push_not_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue pushed while full");

endmodule

@@ rtl/ngpd_back.sv @@
module ngpd_back #(
    parameter int SIDE_MAX  = ngpd_pkg::SIDE_MAX_DEF,
    parameter int MASS_BITS = ngpd_pkg::MASS_BITS_DEF,
    parameter int ACC_BITS  = ngpd_pkg::ACC_BITS_DEF,
    localparam int CELL_W  = $clog2(SIDE_MAX),
    localparam int ADDR_W  = $clog2(SIDE_MAX * SIDE_MAX * SIDE_MAX),
    localparam int ENTRY_W = 1 + ADDR_W + 3 * CELL_W + MASS_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ngpd_pkg::t_q_status             i_q,
    input  logic [ENTRY_W-1:0]              i_entry,
    output logic                            o_pop,
    output ngpd_pkg::t_back_status          o_status,
    output logic                            o_strobe,
    output logic [ngpd_pkg::IDX_W-1:0]      o_out_cell_x,
    output logic [ngpd_pkg::IDX_W-1:0]      o_out_cell_y,
    output logic [ngpd_pkg::IDX_W-1:0]      o_out_cell_z,
    output logic [ngpd_pkg::TOTAL_W-1:0]    o_cell_total,
    output logic                            o_saturated
);
    import ngpd_pkg::*;

    localparam int DEPTH = SIDE_MAX * SIDE_MAX * SIDE_MAX;
    localparam int SUM_W = ((ACC_BITS > MASS_BITS) ? ACC_BITS : MASS_BITS) + 1;
    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

    localparam int OFS_Z    = MASS_BITS;
    localparam int OFS_Y    = MASS_BITS + CELL_W;
    localparam int OFS_X    = MASS_BITS + 2 * CELL_W;
    localparam int OFS_ADDR = MASS_BITS + 3 * CELL_W;

    t_back_state        r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [ENTRY_W-1:0] r_cur;

    logic               r_strobe, n_strobe;
    logic [CELL_W-1:0]  r_cell_x, r_cell_y, r_cell_z;
    logic [ACC_BITS-1:0] r_total, n_total;
    logic               r_sat, n_sat;
    logic               n_load;

    logic               w_we, w_re;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ACC_BITS-1:0] w_wdata, w_rdata;
    logic [SUM_W-1:0]   w_sum;

    ngpd_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (i_entry[OFS_ADDR +: ADDR_W]),
        .o_rdata (w_rdata)
    );

    assign w_sum = SUM_W'(w_rdata) + SUM_W'(r_cur[MASS_BITS-1:0]);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_strobe   = 1'b0;
        n_load     = 1'b0;
        n_total    = w_rdata;
        n_sat      = 1'b0;
        o_pop      = 1'b0;
        w_re       = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_cur[OFS_ADDR +: ADDR_W];
        w_wdata    = '0;
        case (r_state)
            BK_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q.empty) begin
                    o_pop   = 1'b1;
                    w_re    = 1'b1;
                    n_state = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                n_load   = 1'b1;
                n_strobe = 1'b1;
                if (r_cur[ENTRY_W-1] == OP_DEPOSIT) begin
                    if (w_sum > SUM_W'(ACC_MAX)) begin
                        n_total = ACC_MAX;
                        n_sat   = 1'b1;
                    end else begin
                        n_total = ACC_BITS'(w_sum);
                    end
                    w_we    = 1'b1;
                    w_wdata = n_total;
                end
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
        if (n_load) begin
            r_cell_x <= r_cur[OFS_X +: CELL_W];
            r_cell_y <= r_cur[OFS_Y +: CELL_W];
            r_cell_z <= r_cur[OFS_Z +: CELL_W];
            r_total  <= n_total;
            r_sat    <= n_sat;
        end
    end

    assign o_status.clearing = (r_state == BK_CLEAR);

    assign o_strobe     = r_strobe;
    assign o_out_cell_x = IDX_W'(r_cell_x);
    assign o_out_cell_y = IDX_W'(r_cell_y);
    assign o_out_cell_z = IDX_W'(r_cell_z);
    assign o_cell_total = TOTAL_W'(r_total);
    assign o_saturated  = r_sat;

    a_update_strobes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_UPDATE) |=> r_strobe)
        else $error("update without result strobe");

    a_no_result_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CLEAR) |-> !r_strobe)
        else $error("result strobe during clearing pass");

endmodule

@@ test/ngpd_checker.sv @@
module ngpd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ngpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ngpd_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_operation,
    input  logic [ngpd_pkg::POS_W-1:0]     i_pos_x,
    input  logic [ngpd_pkg::POS_W-1:0]     i_pos_y,
    input  logic [ngpd_pkg::POS_W-1:0]     i_pos_z,
    input  logic [ngpd_pkg::MASS_W-1:0]    i_mass,
    input  logic [ngpd_pkg::IDX_W-1:0]     i_read_x,
    input  logic [ngpd_pkg::IDX_W-1:0]     i_read_y,
    input  logic [ngpd_pkg::IDX_W-1:0]     i_read_z,
    input  logic                           i_strobe,
    input  logic [ngpd_pkg::IDX_W-1:0]     i_cell_x,
    input  logic [ngpd_pkg::IDX_W-1:0]     i_cell_y,
    input  logic [ngpd_pkg::IDX_W-1:0]     i_cell_z,
    input  logic [ngpd_pkg::TOTAL_W-1:0]   i_cell_total,
    input  logic                           i_saturated,
    output int                             o_fail_count,
    output int                             o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import ngpd_pkg::*;

    localparam int                 GRID_CELLS = SIDE_MAX_DEF ** 3;
    localparam int                 SCALED_W   = POS_W + SIZE_W + 1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

    typedef struct packed {
        logic [IDX_W-1:0]   x;
        logic [IDX_W-1:0]   y;
        logic [IDX_W-1:0]   z;
        logic [TOTAL_W-1:0] total;
        logic               sat;
    } t_cell_report;

    logic [TOTAL_W-1:0] cell_mass [GRID_CELLS];
    logic [SIZE_W-1:0]  axis_size [3];
    t_cell_report       totals_due [$];
    int                 fail_cnt = 0;
    int                 due_cnt  = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = due_cnt;

    // grid is cleared by reset, sizes come up at 32
    initial begin
        foreach (cell_mass[i]) cell_mass[i] = '0;
        foreach (axis_size[i]) axis_size[i] = SIZE_RESET;
    end

    // scale by size, round half-up, wrap size back to 0
    function automatic logic [IDX_W-1:0] nearest_cell(logic [POS_W-1:0] pos,
                                                      logic [SIZE_W-1:0] size_reg);
        logic [SIZE_W-1:0]   n;
        logic [SCALED_W-1:0] scaled;
        logic [SIZE_W:0]     idx;
        if (size_reg == '0)
            n = SIZE_W'(1);
        else if (size_reg > SIZE_W'(SIDE_MAX_DEF))
            n = SIZE_W'(SIDE_MAX_DEF);
        else
            n = size_reg;
        scaled = SCALED_W'(n) * SCALED_W'(pos)
               + (SCALED_W'(1) << (COORD_FRAC_BITS_DEF - 1));
        idx    = (SIZE_W + 1)'(scaled >> COORD_FRAC_BITS_DEF);
        if (idx >= (SIZE_W + 1)'(n))
            idx = idx - (SIZE_W + 1)'(n);
        return idx[IDX_W-1:0];
    endfunction

    function automatic t_cell_report deposit_or_read();
        t_cell_report         r;
        logic [TOTAL_W-1:0]   prior;
        logic [3*IDX_W-1:0]   addr;
        r.sat = 1'b0;
        if (t_op'(i_operation) == OP_READ) begin
            r.x = i_read_x;
            r.y = i_read_y;
            r.z = i_read_z;
            r.total = cell_mass[{r.x, r.y, r.z}];
        end else begin
            r.x   = nearest_cell(i_pos_x, axis_size[0]);
            r.y   = nearest_cell(i_pos_y, axis_size[1]);
            r.z   = nearest_cell(i_pos_z, axis_size[2]);
            addr  = {r.x, r.y, r.z};
            prior = cell_mass[addr];
            if (TOTAL_W'(i_mass) > TOTAL_MAX - prior) begin
                r.total = TOTAL_MAX;
                r.sat   = 1'b1;
            end else begin
                r.total = prior + TOTAL_W'(i_mass);
            end
            cell_mass[addr] = r.total;
        end
        return r;
    endfunction

    task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SIZE_X: axis_size[0] = i_cfg_wdata;
                    REG_SIZE_Y: axis_size[1] = i_cfg_wdata;
                    REG_SIZE_Z: axis_size[2] = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_strobe) begin
                if (totals_due.size() == 0) begin
                    $write("%0t: unexpected result, expected none, ", $time);
                    $display("got cell (%0d,%0d,%0d) total %0d sat %0d",
                             i_cell_x, i_cell_y, i_cell_z, i_cell_total, i_saturated);
                    fail_cnt++;
                end else begin
                    t_cell_report w;
                    w = totals_due.pop_front();
                    flag_field("cell_x",     w.x,     i_cell_x);
                    flag_field("cell_y",     w.y,     i_cell_y);
                    flag_field("cell_z",     w.z,     i_cell_z);
                    flag_field("cell_total", w.total, i_cell_total);
                    flag_field("saturated",  w.sat,   i_saturated);
                end
            end
            if (i_start && !i_busy)
                totals_due.push_back(deposit_or_read());
        end
        due_cnt = totals_due.size();
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ngpd_pkg::*;

    // generous: reset clear pass over 32768 cells plus ~420 transactions,
    // each with the longest sender gap, several times over
    localparam int                   LIMIT_CYCLES = 300000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;   // no register here
    localparam logic [POS_W-1:0]     POS_MAX      = '1;
    localparam logic [MASS_W-1:0]    MASS_MAX     = '1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SIZE_W-1:0]    i_cfg_wdata;
    logic                 start;
    logic                 busy;
    logic                 i_operation;
    logic [POS_W-1:0]     i_pos_x, i_pos_y, i_pos_z;
    logic [MASS_W-1:0]    i_mass;
    logic [IDX_W-1:0]     i_read_x, i_read_y, i_read_z;
    logic                 o_strobe;
    logic [IDX_W-1:0]     o_out_cell_x, o_out_cell_y, o_out_cell_z;
    logic [TOTAL_W-1:0]   o_cell_total;
    logic                 o_saturated;

    int          fail_count;
    int          pending;
    int unsigned cycle_cnt = 0;
    int          eff_size [3] = '{32, 32, 32};   // sizes in use, for aiming coordinates

    ngp_mass_deposit_3d dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_mass       (i_mass),
        .i_read_x     (i_read_x),
        .i_read_y     (i_read_y),
        .i_read_z     (i_read_z),
        .o_strobe     (o_strobe),
        .o_out_cell_x (o_out_cell_x),
        .o_out_cell_y (o_out_cell_y),
        .o_out_cell_z (o_out_cell_z),
        .o_cell_total (o_cell_total),
        .o_saturated  (o_saturated)
    );

    // watches both channels and the cfg port, predicts every cell total
    ngpd_checker grid_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_start      (start),
        .i_busy       (busy),
        .i_operation  (i_operation),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_mass       (i_mass),
        .i_read_x     (i_read_x),
        .i_read_y     (i_read_y),
        .i_read_z     (i_read_z),
        .i_strobe     (o_strobe),
        .i_cell_x     (o_out_cell_x),
        .i_cell_y     (o_out_cell_y),
        .i_cell_z     (o_out_cell_z),
        .i_cell_total (o_cell_total),
        .i_saturated  (o_saturated),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // watchdog: a hung handshake or a lost result ends up here
    initial begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    // Present one transaction from a falling edge and hold it until the
    // rising edge that takes it. start is left high so that a back-to-back
    // transaction follows without a dip; idle_gap lowers it.
    task automatic issue(t_op op, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                         logic [POS_W-1:0] pz, logic [MASS_W-1:0] m,
                         logic [IDX_W-1:0] rx, logic [IDX_W-1:0] ry,
                         logic [IDX_W-1:0] rz);
        start       = 1'b1;
        i_operation = op;
        i_pos_x     = px;
        i_pos_y     = py;
        i_pos_z     = pz;
        i_mass      = m;
        i_read_x    = rx;
        i_read_y    = ry;
        i_read_z    = rz;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // mostly no gap, often a short one, now and then a long one
    task automatic idle_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (idx != REG_UNUSED)
            eff_size[idx] = (val == '0) ? 1
                          : ((int'(val) > SIDE_MAX_DEF) ? SIDE_MAX_DEF : int'(val));
    endtask

    // Coordinate for one axis: a fair share lands on either side of a
    // rounding threshold (half a cell) for the size in use on that axis.
    function automatic logic [POS_W-1:0] pick_coord(int axis);
        int              r;
        int              n;
        int              k;
        longint unsigned b;
        r = $urandom_range(0, 99);
        n = eff_size[axis];
        if (r < 20) begin
            k = $urandom_range(0, n - 1);
            b = ((2 * k + 1) * (64'd1 << (COORD_FRAC_BITS_DEF - 1)) + n - 1) / n;
            return POS_W'(b - $urandom_range(0, 1));
        end else if (r < 25) begin
            return '0;
        end else if (r < 30) begin
            return POS_MAX;
        end
        return POS_W'($urandom_range(0, 32'h00FF_FFFF));
    endfunction

    // heavy_pct > 0 aims at saturating a cell: few reads, mostly full-scale
    // mass, some zero mass to probe a deposit onto a cell already clipped
    task automatic issue_random(int heavy_pct);
        t_op               op;
        logic [MASS_W-1:0] m;
        int                r;
        op = ($urandom_range(0, 99) < ((heavy_pct > 0) ? 5 : 25)) ? OP_READ : OP_DEPOSIT;
        r  = $urandom_range(0, 99);
        if (heavy_pct > 0)
            m = (r < 8) ? '0 : ((r < 8 + heavy_pct) ? MASS_MAX : $urandom);
        else
            m = (r < 5) ? '0 : ((r < 10) ? MASS_MAX : $urandom);
        issue(op, pick_coord(0), pick_coord(1), pick_coord(2), m,
              IDX_W'($urandom_range(0, 31)), IDX_W'($urandom_range(0, 31)),
              IDX_W'($urandom_range(0, 31)));
    endtask

    // One phase: settle, resize (plus a write to the spare index, which must
    // be ignored), then a run of random transactions. drain_at >= 0 makes the
    // sender hold off until all results are home at that point.
    task automatic run_phase(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                             logic [SIZE_W-1:0] sz, int n_items, int heavy_pct,
                             bit gaps_on, int drain_at);
        drain();
        write_size(REG_SIZE_X, sx);
        write_size(REG_SIZE_Y, sy);
        write_size(REG_SIZE_Z, sz);
        write_size(REG_UNUSED, SIZE_W'($urandom_range(0, 63)));
        for (int i = 0; i < n_items; i++) begin
            issue_random(heavy_pct);
            if (gaps_on)
                idle_gap();
            if (i == drain_at)
                drain();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_SIZE_X;
        i_cfg_wdata = '0;
        start       = 1'b0;
        i_operation = OP_DEPOSIT;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_pos_z     = '0;
        i_mass      = '0;
        i_read_x    = '0;
        i_read_y    = '0;
        i_read_z    = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed, sizes at reset (32 each); the first transaction
        // also waits out the clear pass through busy
        issue(OP_READ, '0, '0, '0, '0, 5'd0, 5'd0, 5'd0);            // cleared
        issue(OP_READ, '0, '0, '0, '0, 5'd31, 5'd31, 5'd31);
        issue(OP_DEPOSIT, '0, '0, '0, MASS_MAX, '0, '0, '0);         // origin
        // top of range rounds up to the size and wraps to cell 0
        issue(OP_DEPOSIT, POS_MAX, POS_MAX, POS_MAX, 32'd1, '0, '0, '0);
        // just on and just below the half-cell threshold
        issue(OP_DEPOSIT, 24'h040000, 24'h03FFFF, 24'h040000, 32'h1234_5678, '0, '0, '0);
        issue(OP_DEPOSIT, 24'h800000, 24'h800000, 24'h800000, 32'd0, '0, '0, '0);
        issue(OP_DEPOSIT, 24'hFBFFFF, 24'hFC0000, 24'h7C0000, 32'hAAAA_AAAA, '0, '0, '0);
        issue(OP_DEPOSIT, 24'hAAAAAA, 24'h555555, 24'hFFFFFF, 32'h5555_5555, '0, '0, '0);
        // same cell back to back: the second read-modify-write sees the first one's write
        issue(OP_DEPOSIT, 24'h800000, 24'h800000, 24'h800000, MASS_MAX, '0, '0, '0);
        issue(OP_DEPOSIT, 24'h800000, 24'h800000, 24'h800000, MASS_MAX, '0, '0, '0);
        issue(OP_READ, '0, '0, '0, '0, 5'd16, 5'd16, 5'd16);
        issue(OP_DEPOSIT, '0, '0, '0, MASS_MAX, '0, '0, '0);
        issue(OP_READ, POS_MAX, POS_MAX, POS_MAX, MASS_MAX, 5'd0, 5'd0, 5'd0);
        issue(OP_READ, '0, '0, '0, '0, 5'd1, 5'd0, 5'd1);
        issue(OP_READ, '0, '0, '0, '0, 5'd31, 5'd0, 5'd16);
        issue(OP_READ, '0, '0, '0, '0, 5'd21, 5'd10, 5'd31);
        issue(OP_READ, '0, '0, '0, '0, 5'd10, 5'd21, 5'd0);

        // --- random phases
        // single cell everywhere: drive the origin into saturation and beyond
        run_phase(6'd1, 6'd1, 6'd1, 320, 90, 1'b1, -1);
        // 0 acts as 1, anything over 32 as 32
        run_phase(6'd0, 6'd63, 6'd33, 15, 0, 1'b1, -1);
        // no idling at all, with one full drain half-way
        run_phase(SIZE_W'($urandom_range(1, 32)), SIZE_W'($urandom_range(1, 32)),
                  SIZE_W'($urandom_range(1, 32)), 20, 0, 1'b0, 10);
        run_phase(6'd3, 6'd5, 6'd7, 15, 0, 1'b1, -1);
        run_phase(6'd32, 6'd32, 6'd32, 15, 0, 1'b1, 7);
        run_phase(SIZE_W'($urandom_range(0, 63)), SIZE_W'($urandom_range(0, 63)),
                  SIZE_W'($urandom_range(0, 63)), 15, 0, 1'b1, -1);

        // --- wind down: all results home, then a margin past the latency
        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ngpd_pkg.sv
rtl/ngpd_ram.sv
rtl/ngpd_front.sv
rtl/ngpd_queue.sv
rtl/ngpd_back.sv
rtl/ngp_mass_deposit_3d.sv
test/ngpd_checker.sv
test/tb_top.sv
